// ===== design/lpmd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpmd_pkg
// Shared types and constants for the length-prefixed message deframer.
// ----------------------------------------------------------------------------
package lpmd_pkg;

    localparam int unsigned LEN_W    = 14;
    localparam int unsigned SEGS_W   = 16;
    localparam int unsigned HDR_W    = 32;
    localparam int unsigned HBS_W    = 3;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned CIDX_W   = 2;
    localparam int unsigned CDATA_W  = 14;
    localparam int unsigned IDATA_W  = 8;
    localparam int unsigned IUSER_W  = 2;
    localparam int unsigned ODATA_W  = 32;
    localparam int unsigned OUSER_W  = 3;

    localparam logic [LEN_W-1:0]  LIMIT_RESET = 14'd16000;
    localparam logic [HDR_W:0]    LEN_BIAS    = 33'd4;
    localparam logic [SEGS_W-1:0] SEGS_MAX    = 16'hFFFF;

    localparam logic [MODE_W-1:0] MODE_SEGMENT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LEN16   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LEN32   = 2'd2;

    localparam logic [CIDX_W-1:0] REG_FRAME_MODE  = 2'd0;
    localparam logic [CIDX_W-1:0] REG_LEN_OFFSET  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_MAX_MSG_LEN = 2'd2;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SYNC = 2'd1,
        ST_ZERO = 2'd2
    } status_t;

    typedef struct packed {
        logic [HBS_W-1:0]  hbs;
        logic [HDR_W-1:0]  hv;
        logic [LEN_W-1:0]  rem;
        logic [LEN_W-1:0]  mlen;
        logic [SEGS_W-1:0] segs;
        logic              drop;
    } dir_state_t;

endpackage

// ===== design/length_prefixed_message_deframer.sv =====
// A request accepted into the input register has its result, if any, placed
// in the result register, which drives the output.
// Throughput: one request per cycle while the output is not stalled; a result
// left untaken holds the next request in the input register.
// Reset (rst_n low, asynchronous): both directions clear their framing state,
// registers return to mode 1, offset 1, limit 16000; no result is pending.
// ----------------------------------------------------------------------------
// length_prefixed_message_deframer
// Finds message boundaries in a two-direction byte stream and reports
// each message length and segment span, or a framing error.
// ----------------------------------------------------------------------------
module length_prefixed_message_deframer
    import lpmd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDATA_W-1:0] cfg_data,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [IDATA_W-1:0] s_axis_tdata,   // [7:0] data_byte
    input  logic [IUSER_W-1:0] s_axis_tuser,   // [0] direction, [1] seg_first
    input  logic               s_axis_tlast,   // seg_last
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [ODATA_W-1:0] m_axis_tdata,   // [13:0] msg_len, [29:14] seg_count, [31:30] 0
    output logic [OUSER_W-1:0] m_axis_tuser    // [0] msg_direction, [2:1] status
);

    logic [MODE_W-1:0]  mode_reg;
    logic               offset_reg;
    logic [LEN_W-1:0]   max_reg;

    logic               in_valid_reg;
    logic [IDATA_W-1:0] in_byte_reg;
    logic               in_dir_reg;
    logic               in_first_reg;
    logic               in_last_reg;

    logic               out_valid_reg;
    logic               out_dir_reg;
    status_t            out_status_reg;
    logic [LEN_W-1:0]   out_len_reg;
    logic [SEGS_W-1:0]  out_segs_reg;

    dir_state_t         st_reg [2];
    dir_state_t         st_next;

    logic               advance;
    logic               res_valid;
    status_t            res_status;
    logic [LEN_W-1:0]   res_len;
    logic [SEGS_W-1:0]  res_segs;

    logic               hdr_mode;
    logic [HBS_W-1:0]   hsize;
    logic [HBS_W:0]     pos;
    logic [HDR_W:0]     total;
    logic [LEN_W:0]     cnt_inc;
    logic [LEN_W-1:0]   rem_dec;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_LEN16;
            offset_reg <= 1'b1;
            max_reg    <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FRAME_MODE:  mode_reg   <= cfg_data[MODE_W-1:0];
                REG_LEN_OFFSET:  offset_reg <= cfg_data[0];
                REG_MAX_MSG_LEN: max_reg    <= cfg_data[LEN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_dir_reg   <= s_axis_tuser[0];
            in_first_reg <= s_axis_tuser[1];
            in_last_reg  <= s_axis_tlast;
        end
    end

    always_comb
    begin
        st_next    = st_reg[in_dir_reg];
        res_valid  = 1'b0;
        res_status = ST_OK;
        res_len    = '0;
        res_segs   = '0;
        hdr_mode   = mode_reg inside {MODE_LEN16, MODE_LEN32};
        hsize      = (mode_reg == MODE_LEN32) ? 3'd4 : (3'd2 + {2'b00, offset_reg});
        pos        = {1'b0, st_next.hbs} + 4'd1;
        total      = '0;
        cnt_inc    = {1'b0, st_next.mlen} + 15'd1;
        rem_dec    = st_next.rem - 14'd1;

        if (in_first_reg)
        begin
            st_next.drop = 1'b0;
            if (!hdr_mode)
            begin
                st_next.hbs  = '0;
                st_next.hv   = '0;
                st_next.rem  = '0;
                st_next.mlen = '0;
                st_next.segs = '0;
            end
            else if (st_next.hbs != '0 || st_next.rem != '0)
            begin
                if (st_next.segs != SEGS_MAX)
                begin
                    st_next.segs = st_next.segs + 16'd1;
                end
            end
        end

        cnt_inc = {1'b0, st_next.mlen} + 15'd1;
        rem_dec = st_next.rem - 14'd1;
        pos     = {1'b0, st_next.hbs} + 4'd1;

        if (!st_next.drop)
        begin
            if (!hdr_mode)
            begin
                if (cnt_inc > {1'b0, max_reg})
                begin
                    res_valid  = 1'b1;
                    res_status = ST_SYNC;
                end
                else if (in_last_reg)
                begin
                    res_valid    = 1'b1;
                    res_status   = ST_OK;
                    res_len      = cnt_inc[LEN_W-1:0];
                    res_segs     = 16'd1;
                    st_next.mlen = '0;
                end
                else
                begin
                    st_next.mlen = cnt_inc[LEN_W-1:0];
                end
            end
            else
            begin
                if (st_next.hbs == '0 && st_next.rem == '0)
                begin
                    st_next.hv   = '0;
                    st_next.segs = 16'd1;
                end
                if (st_next.rem != '0)
                begin
                    st_next.rem = rem_dec;
                    if (rem_dec == '0)
                    begin
                        res_valid  = 1'b1;
                        res_status = ST_OK;
                        res_len    = st_next.mlen;
                        res_segs   = st_next.segs;
                    end
                end
                else
                begin
                    if (mode_reg == MODE_LEN32 || st_next.hbs >= {2'b00, offset_reg})
                    begin
                        st_next.hv = {st_next.hv[HDR_W-9:0], in_byte_reg};
                    end
                    st_next.hbs = pos[HBS_W-1:0];
                    if (pos >= {1'b0, hsize})
                    begin
                        st_next.hbs = '0;
                        if (mode_reg == MODE_LEN16)
                        begin
                            total = {17'd0, st_next.hv[15:0]};
                            if (total == '0)
                            begin
                                res_valid  = 1'b1;
                                res_status = ST_ZERO;
                            end
                            else if (total < {30'd0, hsize})
                            begin
                                total = {30'd0, hsize};
                            end
                        end
                        else
                        begin
                            total = {1'b0, st_next.hv} + LEN_BIAS;
                        end
                        if (!res_valid)
                        begin
                            if (total > {19'd0, max_reg})
                            begin
                                res_valid  = 1'b1;
                                res_status = ST_SYNC;
                            end
                            else
                            begin
                                st_next.mlen = total[LEN_W-1:0];
                                st_next.rem  = total[LEN_W-1:0] - {11'd0, hsize};
                                if (st_next.rem == '0)
                                begin
                                    res_valid  = 1'b1;
                                    res_status = ST_OK;
                                    res_len    = total[LEN_W-1:0];
                                    res_segs   = st_next.segs;
                                end
                            end
                        end
                    end
                end
            end

            if (res_valid && res_status != ST_OK)
            begin
                st_next.hbs  = '0;
                st_next.hv   = '0;
                st_next.rem  = '0;
                st_next.mlen = '0;
                st_next.segs = '0;
                st_next.drop = 1'b1;
                res_len      = '0;
                res_segs     = '0;
            end
        end

        if (in_last_reg)
        begin
            st_next.drop = 1'b0;
        end
    end

    // advance the framing state of the request's direction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg[0] <= '0;
            st_reg[1] <= '0;
        end
        else if (advance)
        begin
            st_reg[in_dir_reg] <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= res_valid;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            out_dir_reg    <= in_dir_reg;
            out_status_reg <= res_status;
            out_len_reg    <= res_len;
            out_segs_reg   <= res_segs;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_segs_reg, out_len_reg};
    assign m_axis_tuser  = {out_status_reg, out_dir_reg};

    a_err_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != ST_OK |-> out_len_reg == '0 && out_segs_reg == '0)
        else $error("error result carries length or segment count");

    a_drop_dir0_clear: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg[0].drop |-> st_reg[0].hbs == '0 && st_reg[0].rem == '0 && st_reg[0].mlen == '0)
        else $error("direction 0 dropping with framing state left");

    a_drop_dir1_clear: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg[1].drop |-> st_reg[1].hbs == '0 && st_reg[1].rem == '0 && st_reg[1].mlen == '0)
        else $error("direction 1 dropping with framing state left");

    a_hbs_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !st_reg[0].hbs[HBS_W-1] && !st_reg[1].hbs[HBS_W-1])
        else $error("header byte count past longest header");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg) && $stable(in_dir_reg))
        else $error("stalled request lost from input register");

endmodule
